/* hw/rtl/uedt_pkg.sv */
// shared types and constants for the undirected edge dedup table
// no dependencies

package uedt_pkg;

    localparam int DEF_MAX_EDGES = 256;
    localparam int VERTEX_W      = 16;
    localparam int INDEX_W       = 8;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef logic [VERTEX_W-1:0] vertex_t;
    typedef logic [INDEX_W-1:0]  index_t;

    typedef struct packed {
        logic load_add;
        logic clear_cnt;
        logic scan_run;
        logic take_match;
        logic finish_miss;
        logic out_load;
    } uedt_cmd_t;

    typedef struct packed {
        logic match;
        logic drained;
        logic out_free;
    } uedt_status_t;

endpackage

/* hw/rtl/uedt_if.sv */
// valid/ready channel interfaces for edge requests and edge results
// depends on uedt_pkg

interface uedt_req_if
    import uedt_pkg::*;
();
    logic    valid;
    logic    ready;
    logic    op;
    vertex_t vertex_a;
    vertex_t vertex_b;

    modport source (output valid, output op, output vertex_a, output vertex_b, input ready);
    modport sink (input valid, input op, input vertex_a, input vertex_b, output ready);
endinterface

interface uedt_rsp_if
    import uedt_pkg::*;
();
    logic   valid;
    logic   ready;
    index_t edge_index;
    logic   is_new;
    logic   table_full;

    modport source (output valid, output edge_index, output is_new, output table_full,
                    input ready);
    modport sink (input valid, input edge_index, input is_new, input table_full,
                  output ready);
endinterface

/* hw/rtl/uedt_ctrl.sv */
// controller state machine for the edge dedup table
// depends on uedt_pkg

module uedt_ctrl
    import uedt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    input  logic         req_op,
    output logic         req_ready,
    input  uedt_status_t status,
    output uedt_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_op == OP_CLEAR)
                    begin
                        cmd.clear_cnt = 1'b1;
                        state_next    = ST_FINISH;
                    end
                    else
                    begin
                        cmd.load_add = 1'b1;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.match)
                begin
                    cmd.take_match = 1'b1;
                    state_next     = ST_FINISH;
                end
                else if (status.drained)
                begin
                    cmd.finish_miss = 1'b1;
                    state_next      = ST_FINISH;
                end
                else
                begin
                    cmd.scan_run = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/uedt_datapath.sv */
// entry memory, count, scan pipeline and result registers of the edge dedup table
// depends on uedt_pkg

module uedt_datapath
    import uedt_pkg::*;
#(
    parameter int MAX_EDGES = DEF_MAX_EDGES
) (
    input  logic         clk,
    input  logic         rst_n,
    input  uedt_cmd_t    cmd,
    output uedt_status_t status,
    input  vertex_t      req_vertex_a,
    input  vertex_t      req_vertex_b,
    input  logic         rsp_ready,
    output logic         rsp_valid,
    output index_t       rsp_edge_index,
    output logic         rsp_is_new,
    output logic         rsp_table_full
);

    localparam int ADDR_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CNT_W  = $clog2(MAX_EDGES + 1);
    localparam int EXT_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    logic [2*VERTEX_W-1:0] mem [MAX_EDGES];

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      issue_reg;
    logic [CNT_W-1:0]      issue_next;
    logic                  rd_valid_reg;
    logic                  rd_valid_next;
    logic [ADDR_W-1:0]     rd_idx_reg;
    logic [2*VERTEX_W-1:0] rd_data_reg;
    vertex_t               a_reg;
    vertex_t               b_reg;
    index_t                res_idx_reg;
    logic                  res_new_reg;
    logic                  res_full_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    index_t                out_idx_reg;
    logic                  out_new_reg;
    logic                  out_full_reg;

    logic                  issue_done;
    logic                  is_full;
    logic                  do_read;
    logic                  do_write;
    vertex_t               rd_first;
    vertex_t               rd_second;
    logic [EXT_W-1:0]      count_ext;
    logic [EXT_W-1:0]      rd_idx_ext;

    assign issue_done = (issue_reg >= count_reg);
    assign is_full    = (count_reg == CNT_W'(MAX_EDGES));
    assign do_read    = cmd.scan_run && !issue_done;
    assign do_write   = cmd.finish_miss && !is_full;
    assign rd_first   = rd_data_reg[2*VERTEX_W-1:VERTEX_W];
    assign rd_second  = rd_data_reg[VERTEX_W-1:0];
    assign count_ext  = EXT_W'(count_reg);
    assign rd_idx_ext = EXT_W'(rd_idx_reg);

    assign status.match = rd_valid_reg &&
        (((rd_first == a_reg) && (rd_second == b_reg)) ||
         ((rd_first == b_reg) && (rd_second == a_reg)));
    assign status.drained  = !rd_valid_reg && issue_done;
    assign status.out_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear_cnt)
        begin
            count_next = '0;
        end
        else if (do_write)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
    end

    always_comb
    begin
        issue_next = issue_reg;
        if (cmd.load_add)
        begin
            issue_next = '0;
        end
        else if (do_read)
        begin
            issue_next = CNT_W'(issue_reg + 1'b1);
        end
    end

    assign rd_valid_next = do_read;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            issue_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // entry memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[count_reg[ADDR_W-1:0]] <= {a_reg, b_reg};
        end
        if (do_read)
        begin
            rd_data_reg <= mem[issue_reg[ADDR_W-1:0]];
            rd_idx_reg  <= issue_reg[ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_add)
        begin
            a_reg <= req_vertex_a;
            b_reg <= req_vertex_b;
        end
        if (cmd.clear_cnt)
        begin
            res_idx_reg  <= '0;
            res_new_reg  <= 1'b0;
            res_full_reg <= 1'b0;
        end
        else if (cmd.take_match)
        begin
            res_idx_reg  <= rd_idx_ext[INDEX_W-1:0];
            res_new_reg  <= 1'b0;
            res_full_reg <= 1'b0;
        end
        else if (cmd.finish_miss)
        begin
            res_idx_reg  <= is_full ? '0 : count_ext[INDEX_W-1:0];
            res_new_reg  <= !is_full;
            res_full_reg <= is_full;
        end
        if (cmd.out_load)
        begin
            out_idx_reg  <= res_idx_reg;
            out_new_reg  <= res_new_reg;
            out_full_reg <= res_full_reg;
        end
    end

    assign rsp_valid      = out_valid_reg;
    assign rsp_edge_index = out_idx_reg;
    assign rsp_is_new     = out_new_reg;
    assign rsp_table_full = out_full_reg;

endmodule

/* hw/rtl/undirected_edge_dedup_table.sv */
// top level of the undirected edge dedup table
// depends on uedt_pkg, uedt_if, uedt_ctrl and uedt_datapath

// Each request transfer is either an add of an edge (a vertex pair) or a clear.
// An add scans the stored entries in index order through the single read port of
// the entry memory, one entry per cycle, and returns the first entry equal to the
// pair in either orientation; with no match the pair is appended and flagged new,
// or flagged table_full when MAX_EDGES entries are held. A clear resets the entry
// count, and its result passes through the finish state into the output register.
// An add leaves the scan on a match or once all stored entries are read, and its
// result is loaded into the output register from the finish state when that
// register is free or being emptied. One request is processed at a time; a
// new request is taken while the previous result still waits in the output
// register. No clearing pass is needed after reset.

module undirected_edge_dedup_table
    import uedt_pkg::*;
#(
    parameter int MAX_EDGES = DEF_MAX_EDGES
) (
    input  logic           clk,
    input  logic           rst_n,
    uedt_req_if.sink       req,
    uedt_rsp_if.source     rsp
);

    uedt_cmd_t    cmd;
    uedt_status_t status;

    uedt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.op),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    uedt_datapath #(
        .MAX_EDGES (MAX_EDGES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .req_vertex_a   (req.vertex_a),
        .req_vertex_b   (req.vertex_b),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .rsp_edge_index (rsp.edge_index),
        .rsp_is_new     (rsp.is_new),
        .rsp_table_full (rsp.table_full)
    );

endmodule

/* verif/undirected_edge_dedup_table_tb.sv */
// testbench for undirected_edge_dedup_table: directed and random add/clear traffic,
// results checked in order against an in-bench model of the edge table
// depends on uedt_pkg, uedt_if and the rtl of undirected_edge_dedup_table

module undirected_edge_dedup_table_tb;
    import uedt_pkg::*;

    localparam int MAX_EDGES   = DEF_MAX_EDGES;
    localparam int ITEM_GOAL   = 1200;
    localparam int PHASE_LEN   = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = MAX_EDGES + 16;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic    op;
        vertex_t vertex_a;
        vertex_t vertex_b;
        bit      drain;
    } edge_req_t;

    typedef struct packed {
        index_t edge_index;
        logic   is_new;
        logic   table_full;
    } edge_result_t;

    logic clk = 1'b0;
    logic rst_n;

    uedt_req_if req_ch ();
    uedt_rsp_if rsp_ch ();

    undirected_edge_dedup_table #(
        .MAX_EDGES (MAX_EDGES)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // model of the table
    vertex_t      model_first [MAX_EDGES];
    vertex_t      model_second [MAX_EDGES];
    int           model_count = 0;
    edge_result_t expected_results [$];

    // stimulus side: pairs added since the last clear
    vertex_t   gen_a [MAX_EDGES];
    vertex_t   gen_b [MAX_EDGES];
    int        gen_n = 0;
    int        gen_total = 0;
    edge_req_t edge_requests [$];

    int reqs_taken = 0;
    bit req_taken = 1'b0;
    int hold_left = 0;
    int hold_count = 0;
    int failures = 0;
    int cycles = 0;

    function automatic edge_result_t lookup_or_insert(logic op, vertex_t a, vertex_t b);
        edge_result_t r;
        r = '0;
        if (op == OP_CLEAR)
        begin
            model_count = 0;
            return r;
        end
        for (int i = 0; i < model_count; i++)
        begin
            if ((model_first[i] == a && model_second[i] == b) ||
                (model_first[i] == b && model_second[i] == a))
            begin
                r.edge_index = index_t'(i);
                return r;
            end
        end
        if (model_count >= MAX_EDGES)
        begin
            r.table_full = 1'b1;
            return r;
        end
        model_first[model_count]  = a;
        model_second[model_count] = b;
        r.edge_index = index_t'(model_count);
        r.is_new     = 1'b1;
        model_count++;
        return r;
    endfunction

    function automatic int gen_find(vertex_t a, vertex_t b);
        for (int k = 0; k < gen_n; k++)
        begin
            if ((gen_a[k] == a && gen_b[k] == b) || (gen_a[k] == b && gen_b[k] == a))
                return k;
        end
        return -1;
    endfunction

    task automatic queue_request(logic op, vertex_t a, vertex_t b, bit drain);
        edge_req_t it;
        it.op       = op;
        it.vertex_a = a;
        it.vertex_b = b;
        it.drain    = drain;
        edge_requests.push_back(it);
        gen_total++;
    endtask

    task automatic gen_clear(bit drain);
        queue_request(OP_CLEAR, vertex_t'($urandom), vertex_t'($urandom), drain);
        gen_n = 0;
    endtask

    task automatic gen_add(vertex_t a, vertex_t b);
        queue_request(OP_ADD, a, b, 1'b0);
        if (gen_find(a, b) < 0 && gen_n < MAX_EDGES)
        begin
            gen_a[gen_n] = a;
            gen_b[gen_n] = b;
            gen_n++;
        end
    endtask

    task automatic pick_fresh(output vertex_t a, output vertex_t b);
        do
        begin
            a = vertex_t'($urandom);
            b = ($urandom_range(0, 19) == 0) ? a : vertex_t'($urandom);
        end
        while (gen_find(a, b) >= 0);
    endtask

    // fresh pair, exact repeat in either orientation, or a pair sharing one vertex
    task automatic add_mixed(int fresh_pct, int repeat_pct);
        vertex_t a;
        vertex_t b;
        int      k;
        int      r;
        r = $urandom_range(0, 99);
        if (gen_n == 0 || r < fresh_pct)
            pick_fresh(a, b);
        else
        begin
            k = ($urandom_range(0, 4) == 0) ? gen_n - 1 : $urandom_range(0, gen_n - 1);
            a = gen_a[k];
            b = gen_b[k];
            if (r < fresh_pct + repeat_pct)
            begin
                if ($urandom_range(0, 1) == 1)
                    {a, b} = {b, a};
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: b = vertex_t'($urandom);
                    1: a = vertex_t'($urandom);
                    2:
                    begin
                        a = gen_b[k];
                        b = vertex_t'($urandom);
                    end
                    default:
                    begin
                        b = gen_a[k];
                        a = vertex_t'($urandom);
                    end
                endcase
            end
        end
        gen_add(a, b);
    endtask

    // request driver
    always @(negedge clk)
    begin : req_driver
        int        phase;
        int        idle_pct;
        bit        wait_now;
        edge_req_t it;
        phase    = (reqs_taken / PHASE_LEN) % 4;
        idle_pct = (phase == 1) ? 85 : (phase == 3) ? 6 : 0;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (req_taken || !req_ch.valid)
        begin
            wait_now = (hold_left == 0 && $urandom_range(0, 99) < idle_pct);
            if (edge_requests.size() != 0 && edge_requests[0].drain &&
                expected_results.size() != 0)
                wait_now = 1'b1;
            if (edge_requests.size() != 0 && !wait_now)
            begin
                it = edge_requests.pop_front();
                req_ch.valid    <= 1'b1;
                req_ch.op       <= it.op;
                req_ch.vertex_a <= it.vertex_a;
                req_ch.vertex_b <= it.vertex_b;
            end
            else
                req_ch.valid <= 1'b0;
        end
        req_taken = 1'b0;
    end

    // result receiver, with long hold-offs to back up the request side
    always @(negedge clk)
    begin : rsp_receiver
        int phase;
        int stall_pct;
        phase     = (reqs_taken / PHASE_LEN) % 4;
        stall_pct = (phase == 2) ? 85 : (phase == 3) ? 6 : 0;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (hold_left > 0)
                hold_left <= hold_left - 1;
            else if (hold_count < 2 && reqs_taken >= 60 + hold_count * 600)
            begin
                hold_left  <= HOLD_CYCLES;
                hold_count <= hold_count + 1;
            end
            rsp_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // transfer monitor and result check
    always @(posedge clk)
    begin : transfer_monitor
        edge_result_t want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_results.push_back(
                    lookup_or_insert(req_ch.op, req_ch.vertex_a, req_ch.vertex_b));
                reqs_taken++;
                req_taken = 1'b1;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no request pending");
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_ch.edge_index !== want.edge_index)
                    begin
                        $error("edge_index: expected %0d, got %0d",
                               want.edge_index, rsp_ch.edge_index);
                        failures++;
                    end
                    if (rsp_ch.is_new !== want.is_new)
                    begin
                        $error("is_new: expected %0b, got %0b", want.is_new, rsp_ch.is_new);
                        failures++;
                    end
                    if (rsp_ch.table_full !== want.table_full)
                    begin
                        $error("table_full: expected %0b, got %0b",
                               want.table_full, rsp_ch.table_full);
                        failures++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int fills;
        int epoch;
        int n_adds;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.op       = OP_ADD;
        req_ch.vertex_a = '0;
        req_ch.vertex_b = '0;
        rsp_ch.ready    = 1'b0;

        // directed: extremes, both orientations, shared vertex, equal vertices,
        // stale entries after a clear
        gen_clear(1'b1);
        gen_add(16'h0000, 16'h0000);
        gen_add(16'hFFFF, 16'hFFFF);
        gen_add(16'h0000, 16'hFFFF);
        gen_add(16'hFFFF, 16'h0000);
        gen_add(16'h0000, 16'h0000);
        gen_add(16'h1234, 16'h5678);
        gen_add(16'h5678, 16'h1234);
        gen_add(16'h1234, 16'h0000);
        gen_add(16'h5678, 16'h5678);
        gen_add(16'h5678, 16'h5678);
        gen_add(16'hFFFF, 16'hFFFF);
        queue_request(OP_CLEAR, 16'h1234, 16'h5678, 1'b1);
        gen_n = 0;
        gen_add(16'h1234, 16'h5678);
        gen_add(16'h0000, 16'h0000);
        gen_add(16'hFFFF, 16'h0000);
        gen_add(16'h0000, 16'hFFFF);

        // random: full-table fills and short sessions
        fills = 0;
        epoch = 0;
        while (gen_total < ITEM_GOAL)
        begin
            if (fills < 2 && (epoch == 0 || gen_total >= 650))
            begin
                gen_clear(1'b1);
                while (gen_n < MAX_EDGES)
                    add_mixed(100, 0);
                add_mixed(100, 0);
                gen_add(gen_a[MAX_EDGES-1], gen_b[MAX_EDGES-1]);
                gen_add(gen_b[0], gen_a[0]);
                repeat (40)
                    add_mixed(30, 30);
                fills++;
            end
            else
            begin
                gen_clear($urandom_range(0, 3) == 0);
                n_adds = $urandom_range(1, 40);
                repeat (n_adds)
                begin
                    if ($urandom_range(0, 99) < 3)
                        gen_clear(1'b0);
                    else
                        add_mixed(45, 30);
                end
            end
            epoch++;
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (edge_requests.size() != 0 || req_ch.valid)
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
